FILE: rtl/oqkr_pkg.sv
// shared types and constants for the ordered queue with keyed removal
`default_nettype none
package oqkr_pkg;

  localparam int DEFAULT_QUEUE_DEPTH = 16;

  localparam int MODE_W   = 3;
  localparam int KEY_W    = 16;
  localparam int HANDLE_W = 16;
  localparam int COUNT_W  = 5;

  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 40;

  // operation codes carried in the mode field
  localparam logic [MODE_W-1:0] MODE_PUSH          = 3'd0;
  localparam logic [MODE_W-1:0] MODE_POP           = 3'd1;
  localparam logic [MODE_W-1:0] MODE_REMOVE_KEY    = 3'd2;
  localparam logic [MODE_W-1:0] MODE_LOOKUP_KEY    = 3'd3;
  localparam logic [MODE_W-1:0] MODE_REMOVE_HANDLE = 3'd4;

  typedef struct packed {
    logic [HANDLE_W-1:0] handle;
    logic [KEY_W-1:0]    id;
  } entry_t;

  // decoded operation broadcast to every cell
  typedef struct packed {
    logic push;
    logic pop;
    logic by_key;
    logic by_handle;
    logic remove;
  } op_t;

endpackage
`default_nettype wire

FILE: rtl/oqkr_cell.sv
// one queue slot: stores an entry, compares it and shifts toward the head
`default_nettype none
module oqkr_cell (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire  oqkr_pkg::op_t                 op,
  input  wire  [oqkr_pkg::KEY_W-1:0]          key,
  input  wire  [oqkr_pkg::HANDLE_W-1:0]       hnd,
  input  wire                                 prev_valid,
  input  wire                                 next_valid,
  input  wire  oqkr_pkg::entry_t              next_entry,
  input  wire                                 hit_in,
  input  wire  oqkr_pkg::entry_t              hit_entry_in,
  output logic                                valid,
  output oqkr_pkg::entry_t                    entry,
  output logic                                hit_out,
  output oqkr_pkg::entry_t                    hit_entry_out
);

  logic match;
  logic shift_in;
  logic load_push;

  always_comb begin
    match = valid & (op.pop |
                     (op.by_key & (entry.id == key)) |
                     (op.by_handle & (entry.handle == hnd)));
    hit_out = hit_in | match;
    if (hit_in) begin
      hit_entry_out = hit_entry_in;
    end else if (match) begin
      hit_entry_out = entry;
    end else begin
      hit_entry_out = '0;
    end
    // at or past the removed slot every cell takes its neighbor's contents
    shift_in  = op.remove & hit_out;
    load_push = op.push & ~valid & prev_valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (shift_in) begin
      valid <= next_valid;
    end else if (load_push) begin
      valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (shift_in) begin
      entry <= next_entry;
    end else if (load_push) begin
      entry.handle <= hnd;
      entry.id     <= key;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/ordered_queue_with_keyed_removal_core.sv
// top level: ordered queue with keyed removal built from a row of slot cells
//
// channel  dir  handshake          payload
// s_*      in   s_tvalid/s_tready  s_tdata: mode, key_id, handle
// m_*      out  m_tvalid/m_tready  m_tdata: found, hit_handle, hit_id, overflow, entry_count
//
// each operation runs in two steps: the transfer is registered, then in the
// compute cycle every cell compares at once, the first-hit chain ripples along
// the row and the row shifts or loads; no new transfer is taken before that compute cycle
// reset clears the valid bit of every cell and the count; entries need no reset
// a stalled result holds the row: the compute cycle waits until the output
// register is free; one more transfer is taken while a result waits, then
// s_tready stays low until that result leaves
`default_nettype none
module ordered_queue_with_keyed_removal_core #(
  parameter int QUEUE_DEPTH = oqkr_pkg::DEFAULT_QUEUE_DEPTH
) (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                s_tvalid,
  output logic                               s_tready,
  // mode [2:0], key_id [18:3], handle [34:19], zero fill [39:35]
  input  wire  [oqkr_pkg::IN_TDATA_W-1:0]    s_tdata,
  output logic                               m_tvalid,
  input  wire                                m_tready,
  // found [0], hit_handle [16:1], hit_id [32:17], overflow [33],
  // entry_count [38:34], zero fill [39]
  output logic [oqkr_pkg::OUT_TDATA_W-1:0]   m_tdata
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  // registered operation
  logic                              busy;
  oqkr_pkg::op_t                     op_q;
  logic [oqkr_pkg::KEY_W-1:0]        key_q;
  logic [oqkr_pkg::HANDLE_W-1:0]     hnd_q;
  logic [CNT_W-1:0]                  occupancy;
  logic [CNT_W-1:0]                  occupancy_next;

  logic                              in_xfer;
  logic                              step;
  oqkr_pkg::op_t                     op_dec;
  oqkr_pkg::op_t                     op_eff;
  logic [oqkr_pkg::MODE_W-1:0]       in_mode;

  // links between neighboring cells
  logic                              cell_valid [QUEUE_DEPTH];
  oqkr_pkg::entry_t                  cell_entry [QUEUE_DEPTH];
  logic                              hit_link   [QUEUE_DEPTH+1];
  oqkr_pkg::entry_t                  hit_entry  [QUEUE_DEPTH+1];

  logic                              full;
  logic                              found;
  logic                              overflow;
  logic [31:0]                       count_wide;

  assign in_mode  = s_tdata[2:0];
  assign s_tready = ~busy;
  assign in_xfer  = s_tvalid & s_tready;
  // compute cycle commits only when the output register can take the result
  assign step     = busy & (~m_tvalid | m_tready);
  assign op_eff   = step ? op_q : '0;

  always_comb begin
    op_dec = '0;
    unique case (in_mode)
      oqkr_pkg::MODE_PUSH: begin
        op_dec.push = 1'b1;
      end
      oqkr_pkg::MODE_POP: begin
        op_dec.pop    = 1'b1;
        op_dec.remove = 1'b1;
      end
      oqkr_pkg::MODE_REMOVE_KEY: begin
        op_dec.by_key = 1'b1;
        op_dec.remove = 1'b1;
      end
      oqkr_pkg::MODE_LOOKUP_KEY: begin
        op_dec.by_key = 1'b1;
      end
      oqkr_pkg::MODE_REMOVE_HANDLE: begin
        op_dec.by_handle = 1'b1;
        op_dec.remove    = 1'b1;
      end
      default: begin
        op_dec = '0;  // unused codes do nothing
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (in_xfer) begin
      busy <= 1'b1;
    end else if (step) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      op_q  <= op_dec;
      key_q <= s_tdata[18:3];
      hnd_q <= s_tdata[34:19];
    end
  end

  // head of the row has no left neighbor, tail has no right neighbor
  assign hit_link[0]  = 1'b0;
  assign hit_entry[0] = '0;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic             prev_v;
    logic             next_v;
    oqkr_pkg::entry_t next_e;

    if (i == 0) begin : g_head
      assign prev_v = 1'b1;
    end else begin : g_body
      assign prev_v = cell_valid[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign next_v = 1'b0;
      assign next_e = '0;
    end else begin : g_inner
      assign next_v = cell_valid[i+1];
      assign next_e = cell_entry[i+1];
    end

    oqkr_cell u_cell (
      .clk           (clk),
      .rst           (rst),
      .op            (op_eff),
      .key           (key_q),
      .hnd           (hnd_q),
      .prev_valid    (prev_v),
      .next_valid    (next_v),
      .next_entry    (next_e),
      .hit_in        (hit_link[i]),
      .hit_entry_in  (hit_entry[i]),
      .valid         (cell_valid[i]),
      .entry         (cell_entry[i]),
      .hit_out       (hit_link[i+1]),
      .hit_entry_out (hit_entry[i+1])
    );
  end

  assign full     = cell_valid[QUEUE_DEPTH-1];
  assign found    = hit_link[QUEUE_DEPTH];
  assign overflow = op_q.push & full;

  always_comb begin
    occupancy_next = occupancy;
    if (op_q.push & ~full) begin
      occupancy_next = occupancy + 1'b1;
    end else if (op_q.remove & found) begin
      occupancy_next = occupancy - 1'b1;
    end
    count_wide = 32'(occupancy_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occupancy <= '0;
    end else if (step) begin
      occupancy <= occupancy_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (step) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      m_tdata <= {1'b0, count_wide[4:0], overflow,
                  hit_entry[QUEUE_DEPTH].id, hit_entry[QUEUE_DEPTH].handle, found};
    end
  end

endmodule
`default_nettype wire
